FILE: rtl/core/iqpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and helpers for the IQ pre-trigger capture block.
// Self-contained; used by iqpc_cell and iq_pretrigger_capture_top.
package iqpc_pkg;

  localparam int unsigned SAMPLE_W = 14;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_AW-1:0] REG_CAPTURE_MODE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TRIGGER_LEVEL = 2'd1;
  localparam logic [CFG_AW-1:0] REG_POST_COUNT    = 2'd2;

  // Capture modes; the fourth code is reserved and behaves as off.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_TRIG = 2'd2;

  localparam logic [1:0]          RST_MODE  = MODE_TRIG;
  localparam logic [SAMPLE_W-1:0] RST_LEVEL = 14'd4096;
  localparam logic [15:0]         RST_POST  = 16'd256;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } sample_t;

  typedef struct packed {
    sample_t s;
    logic    last;
  } result_t;

  // Magnitude of a 14-bit two's complement value; the most negative code gives 8192,
  // which still fits in 14 unsigned bits.
  function automatic logic [SAMPLE_W-1:0] iqpc_mag(input logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] u;
    begin
      u = x;
      iqpc_mag = x[SAMPLE_W-1] ? (~u + 1'b1) : u;
    end
  endfunction

endpackage

FILE: rtl/core/iqpc_cell.sv
`timescale 1ns / 1ps
// One cell of the pre-trigger history chain: holds a single IQ sample.
// Depends on iqpc_pkg for the sample type.
module iqpc_cell import iqpc_pkg::*; (
  input  logic    clk,
  input  logic    shift_en,
  input  sample_t d,
  output sample_t q
);

  sample_t data_r;

  // Payload only, so no reset: entries are qualified by the fill count upstream.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d;
    end
  end

  assign q = data_r;

endmodule

FILE: rtl/core/iq_pretrigger_capture_top.sv
`timescale 1ns / 1ps
// IQ pre-trigger capture. Each request carries one 32-bit word holding a 14-bit I sample
// in bits 29..16 and a 14-bit Q sample in bits 13..0. In full mode every sample is passed
// on as one result; in trigger mode every sample is also pushed into a history chain of
// PRE_DEPTH cells, and a sample whose |I| or |Q| strictly exceeds trigger_level (while no
// capture is running) dumps the history oldest first, ending with the triggering sample,
// after which the next post_count samples are each passed on. Off and the reserved mode
// produce nothing. One request per cycle is accepted while the two-entry result buffer has
// room and no dump is running. A trigger occupies the block for one full rotation of the cell
// chain, which brings the history back into place; the rotation stalls while a result is due
// and the result buffer is full, and no input request is accepted during that dump.
// Configuration may be written at any time the block is idle; writes to an unknown index
// are ignored. Depends on iqpc_pkg and iqpc_cell.
module iq_pretrigger_capture_top import iqpc_pkg::*; #(
  parameter int unsigned PRE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input requests.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_raw_word,
  // Result requests.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_i_sample,
  output logic signed [SAMPLE_W-1:0] out_q_sample,
  output logic                       out_last_of_run,
  // Configuration writes.
  input  logic                       cfg_we,
  input  logic [CFG_AW-1:0]          cfg_addr,
  input  logic [CFG_DW-1:0]          cfg_wdata
);

  // Step counter over one chain rotation, fill count of the history and the width
  // needed to compare their sum against the depth.
  localparam int unsigned SW = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PRE_DEPTH + 1);
  localparam int unsigned EW = CW + 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(PRE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_FILL = CW'(PRE_DEPTH);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  // Configuration registers.
  logic [1:0]          mode_r;
  logic [SAMPLE_W-1:0] level_r;
  logic [15:0]         post_cnt_r;

  // Control state.
  state_t        state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          capturing_r, capturing_nxt;
  logic [15:0]   post_left_r, post_left_nxt;

  // Two-entry result buffer, so a waiting result does not hold up the input side.
  result_t     obuf_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  ocnt_r, ocnt_nxt;

  // History chain.
  sample_t cell_q [PRE_DEPTH];
  sample_t chain_in;
  logic    shift_en;

  sample_t new_s;
  logic    in_acc;
  logic    trig;
  logic    emit;
  logic    push;
  result_t push_data;
  logic    pop;
  logic    obuf_full;

  assign new_s.i   = in_raw_word[29:16];
  assign new_s.q   = in_raw_word[13:0];
  assign obuf_full = (ocnt_r == 2'd2);
  assign in_ready  = (state_r == S_IDLE) && !obuf_full;
  assign in_acc    = in_valid && in_ready;
  assign trig      = (iqpc_mag(new_s.i) > level_r) || (iqpc_mag(new_s.q) > level_r);

  // During a dump, step j presents the cell that was originally at depth PRE_DEPTH-1-j at
  // the tail; it holds a written sample only if that depth lies inside the fill count.
  assign emit = (EW'(step_r) + EW'(fill_r)) >= EW'(PRE_DEPTH);

  // The chain's head takes the new sample normally and the tail while rotating.
  assign chain_in = (state_r == S_DUMP) ? cell_q[PRE_DEPTH-1] : new_s;

  genvar k;
  generate
    for (k = 0; k < PRE_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
        iqpc_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d        (chain_in),
          .q        (cell_q[k])
        );
      end else begin : g_body
        iqpc_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d        (cell_q[k-1]),
          .q        (cell_q[k])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    fill_nxt       = fill_r;
    capturing_nxt  = capturing_r;
    post_left_nxt  = post_left_r;
    shift_en       = 1'b0;
    push           = 1'b0;
    push_data.s    = new_s;
    push_data.last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (mode_r)
            MODE_FULL: begin
              push = 1'b1;
            end
            MODE_TRIG: begin
              shift_en = 1'b1;
              if (fill_r != FULL_FILL) begin
                fill_nxt = fill_r + 1'b1;
              end
              if (capturing_r) begin
                // A running capture always has at least one sample left here.
                push          = 1'b1;
                post_left_nxt = post_left_r - 1'b1;
                capturing_nxt = (post_left_r != 16'd1);
              end else if (trig) begin
                state_nxt     = S_DUMP;
                step_nxt      = '0;
                post_left_nxt = post_cnt_r;
                capturing_nxt = (post_cnt_r != 16'd0);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        push_data.s    = cell_q[PRE_DEPTH-1];
        push_data.last = (step_r == LAST_STEP);
        // Steps holding unwritten cells rotate without producing a result.
        if (!emit || !obuf_full) begin
          shift_en = 1'b1;
          push     = emit;
          if (step_r == LAST_STEP) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pop = (ocnt_r != 2'd0) && out_ready;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (push && !pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!push && pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      fill_r      <= '0;
      capturing_r <= 1'b0;
      post_left_r <= '0;
      mode_r      <= RST_MODE;
      level_r     <= RST_LEVEL;
      post_cnt_r  <= RST_POST;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      ocnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fill_r      <= fill_nxt;
      capturing_r <= capturing_nxt;
      post_left_r <= post_left_nxt;
      ocnt_r      <= ocnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_CAPTURE_MODE:  mode_r     <= cfg_wdata[1:0];
          REG_TRIGGER_LEVEL: level_r    <= cfg_wdata[SAMPLE_W-1:0];
          REG_POST_COUNT:    post_cnt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Result buffer storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      obuf_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid       = (ocnt_r != 2'd0);
  assign out_i_sample    = obuf_r[rd_ptr_r].s.i;
  assign out_q_sample    = obuf_r[rd_ptr_r].s.q;
  assign out_last_of_run = obuf_r[rd_ptr_r].last;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for iq_pretrigger_capture_top: directed and random IQ words are
// sent over valid/ready while results are checked against a predictor of the capture.
// Depends on iqpc_pkg and the RTL of iq_pretrigger_capture_top.
module testbench import iqpc_pkg::*;;

  // Depth of the history ring, passed to the block as well.
  localparam int unsigned DEPTH = 32;
  localparam int unsigned RING_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Extra cycles after the last result: a trigger keeps the block busy for one rotation.
  localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
  // Codes that the package does not name: the reserved mode and the unused register index.
  localparam logic [1:0]        MODE_RESERVED = 2'd3;
  localparam logic [CFG_AW-1:0] REG_UNUSED    = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [31:0]                in_raw_word = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_i_sample;
  logic signed [SAMPLE_W-1:0] out_q_sample;
  logic                       out_last_of_run;
  logic                       cfg_we = 1'b0;
  logic [CFG_AW-1:0]          cfg_addr = '0;
  logic [CFG_DW-1:0]          cfg_wdata = '0;

  iq_pretrigger_capture_top #(
    .PRE_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_word    (in_raw_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_i_sample   (out_i_sample),
    .out_q_sample   (out_q_sample),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // The predictor's own copy of the registers, as they come out of reset.
  logic [1:0]          mode_r  = MODE_TRIG;
  logic [SAMPLE_W-1:0] level_r = 14'd4096;
  logic [15:0]         post_r  = 16'd256;

  // The predictor's own copy of the capture state.
  logic [SAMPLE_W-1:0] ring_i [DEPTH];
  logic [SAMPLE_W-1:0] ring_q [DEPTH];
  int unsigned         slot_r      = 0;
  bit                  wrapped_r   = 1'b0;
  bit                  capturing_r = 1'b0;
  int unsigned         post_left_r = 0;

  // Samples that the block owes us, oldest first.
  result_t pending_samples[$];

  // Magnitude of a 14-bit two's complement pattern; the most negative code gives 8192.
  function automatic int unsigned sample_magnitude(input logic [SAMPLE_W-1:0] x);
    int unsigned u;
    u = 32'(x);
    return x[SAMPLE_W-1] ? (16384 - u) : u;
  endfunction

  task automatic owe_sample(input logic [SAMPLE_W-1:0] i, input logic [SAMPLE_W-1:0] q,
                            input bit last);
    result_t r;
    r.s.i  = i;
    r.s.q  = q;
    r.last = last;
    pending_samples.push_back(r);
  endtask

  // Works out what one accepted word makes the block emit, and moves the state on.
  task automatic predict_capture(input logic [31:0] w);
    logic [SAMPLE_W-1:0] si;
    logic [SAMPLE_W-1:0] sq;
    int unsigned         first;
    int unsigned         count;
    int unsigned         pos;
    si = w[29:16];
    sq = w[13:0];
    if (mode_r == MODE_FULL) begin
      owe_sample(si, sq, 1'b1);
    end else if (mode_r == MODE_TRIG) begin
      ring_i[RING_AW'(slot_r)] = si;
      ring_q[RING_AW'(slot_r)] = sq;
      slot_r = (slot_r + 1) % DEPTH;
      if (slot_r == 0) wrapped_r = 1'b1;
      if (capturing_r) begin
        // Post-trigger sample: passed straight on.
        owe_sample(si, sq, 1'b1);
        if (post_left_r > 0) post_left_r--;
        if (post_left_r == 0) capturing_r = 1'b0;
      end else if (sample_magnitude(si) > 32'(level_r) ||
                   sample_magnitude(sq) > 32'(level_r)) begin
        // Trigger: dump the history oldest first, the triggering sample last.
        first = wrapped_r ? slot_r : 0;
        count = wrapped_r ? DEPTH : slot_r;
        for (int unsigned j = 0; j < count; j++) begin
          pos = (first + j) % DEPTH;
          owe_sample(ring_i[RING_AW'(pos)], ring_q[RING_AW'(pos)], j + 1 == count);
        end
        post_left_r = 32'(post_r);
        capturing_r = (post_left_r != 0);
      end
    end
  endtask

  // Receiver: ready is drawn afresh every cycle from the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Each accepted result request is compared field by field with the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result i=%0d q=%0d last=%0b", $time,
                 out_i_sample, out_q_sample, out_last_of_run);
      end else begin
        want = pending_samples.pop_front();
        if (out_i_sample !== want.s.i) begin
          mismatch_count++;
          $display("%0t: i_sample expected %0d, got %0d", $time, want.s.i, out_i_sample);
        end
        if (out_q_sample !== want.s.q) begin
          mismatch_count++;
          $display("%0t: q_sample expected %0d, got %0d", $time, want.s.q, out_q_sample);
        end
        if (out_last_of_run !== want.last) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %0b, got %0b", $time, want.last,
                   out_last_of_run);
        end
      end
    end
  end

  // Sends one word as an input request. Valid stays high from one request to the next
  // unless the sender decides to idle, so it is never lowered and raised in one step.
  task automatic send_word(input logic [31:0] w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_raw_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_capture(w);
  endtask

  // Stops sending, waits for every owed result and then for the block to finish any dump.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges, once the block has gone quiet.
  task automatic configure(input logic [1:0] mode, input logic [SAMPLE_W-1:0] level,
                           input logic [15:0] post);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_CAPTURE_MODE;
    cfg_wdata <= {{(CFG_DW - 2){1'b0}}, mode};
    @(posedge clk);
    mode_r     = mode;
    cfg_addr  <= REG_TRIGGER_LEVEL;
    cfg_wdata <= {{(CFG_DW - SAMPLE_W){1'b0}}, level};
    @(posedge clk);
    level_r    = level;
    cfg_addr  <= REG_POST_COUNT;
    cfg_wdata <= post;
    @(posedge clk);
    post_r  = post;
    cfg_we <= 1'b0;
  endtask

  // One 14-bit component: quiet ones stay within the level, loud ones exceed it.
  function automatic logic [SAMPLE_W-1:0] pick_component(input int unsigned level,
                                                         input bit loud);
    int unsigned mag;
    bit          neg;
    neg = 1'($urandom_range(0, 1));
    if (loud) mag = $urandom_range(level + 1, 8192);
    else      mag = $urandom_range(0, (level > 8192) ? 8192 : level);
    // +8192 does not exist, so that magnitude is always the most negative code.
    if (mag == 8192) neg = 1'b1;
    return neg ? SAMPLE_W'(16384 - mag) : SAMPLE_W'(mag);
  endfunction

  // A word with random padding bits; a loud word has at least one loud component.
  function automatic logic [31:0] make_word(input int unsigned level, input bit loud);
    logic [SAMPLE_W-1:0] i;
    logic [SAMPLE_W-1:0] q;
    bit                  i_loud;
    i_loud = loud && $urandom_range(0, 1);
    i = pick_component(level, i_loud || (loud && $urandom_range(0, 3) == 0));
    q = pick_component(level, loud && !i_loud);
    return {2'($urandom_range(0, 3)), i, 2'($urandom_range(0, 3)), q};
  endfunction

  // One random phase: mostly quiet words with occasional triggers, plus raw noise.
  task automatic run_phase(input int unsigned n, input logic [1:0] mode,
                           input int unsigned level, input logic [15:0] post,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned loud_pct);
    int unsigned dice;
    logic [31:0] w;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    configure(mode, SAMPLE_W'(level), post);
    for (int unsigned k = 0; k < n; k++) begin
      dice = $urandom_range(0, 99);
      if (dice < 10)                                w = $urandom();
      else if (dice < 10 + loud_pct && level < 8192) w = make_word(level, 1'b1);
      else                                          w = make_word(level, 1'b0);
      send_word(w);
    end
  endtask

  // Out of reset the block is in trigger mode at level 4096: a sample of exactly that
  // magnitude must not trigger, so no result is owed.
  task automatic test_reset_values();
    send_word({2'b00, 14'h1000, 2'b00, 14'h3000});
  endtask

  // Full mode passes every sample on, including the field extremes and padding bits.
  task automatic test_full_mode();
    configure(MODE_FULL, 14'd4096, 16'd4);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word({2'b00, 14'h1FFF, 2'b11, 14'h2000});
    send_word({2'b11, 14'h2000, 2'b00, 14'h1FFF});
  endtask

  // Off and the reserved mode emit nothing; a write to the unused index changes nothing.
  task automatic test_off_and_reserved();
    configure(MODE_OFF, 14'd50, 16'd7);
    send_word({2'b01, 14'h2000, 2'b10, 14'h1FFF});
    configure(MODE_RESERVED, 14'd50, 16'd7);
    send_word({2'b10, 14'h1FFF, 2'b01, 14'h2000});
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_UNUSED;
    cfg_wdata <= {CFG_DW{1'b1}};
    @(posedge clk);
    cfg_we <= 1'b0;
    send_word({2'b00, 14'h2000, 2'b00, 14'h2000});
  endtask

  // A trigger on a partly filled ring, post-trigger samples that must not retrigger,
  // a sample exactly at the level, and a second trigger on a negative Q.
  task automatic test_trigger_capture();
    configure(MODE_TRIG, 14'd100, 16'd2);
    send_word({2'b00, 14'd101, 2'b00, 14'd3});
    send_word({2'b00, 14'h2000, 2'b00, 14'h1FFF});
    send_word({2'b00, 14'd5, 2'b00, 14'd6});
    send_word({2'b00, 14'd7, 2'b00, 14'd8});
    send_word({2'b00, 14'd100, 2'b00, 14'h3F9C});
    send_word({2'b00, 14'd9, 2'b00, 14'h3F9B});
  endtask

  // A capture is left running across a change to full mode and resumes afterwards.
  task automatic test_mode_change_in_capture();
    configure(MODE_FULL, 14'd100, 16'd2);
    send_word({2'b00, 14'd11, 2'b00, 14'd12});
    configure(MODE_TRIG, 14'd100, 16'd2);
    send_word({2'b00, 14'h3000, 2'b00, 14'd13});
    send_word({2'b00, 14'd14, 2'b00, 14'd15});
  endtask

  // With no post-trigger samples the capture ends after the dump, so the very next
  // loud sample triggers again.
  task automatic test_zero_post_count();
    configure(MODE_TRIG, 14'd100, 16'd0);
    send_word({2'b00, 14'd16, 2'b00, 14'd17});
    send_word({2'b00, 14'd200, 2'b00, 14'd18});
    send_word({2'b00, 14'd19, 2'b00, 14'h3E00});
  endtask

  // Random phases over the idling profiles and the register extremes. The longest post
  // count comes last, since that capture never finishes within the run.
  task automatic test_random_capture();
    run_phase(50, MODE_TRIG, 2000, 16'd3,     0,  0, 6);
    run_phase(30, MODE_TRIG, 0,    16'd1,     48, 0, 10);
    run_phase(30, MODE_TRIG, 8192, 16'd5,     0,  48, 0);
    run_phase(50, MODE_TRIG, 600,  16'd2,     18, 18, 4);
    run_phase(20, MODE_FULL, 300,  16'd9,     0,  48, 20);
    run_phase(30, MODE_TRIG, 8191, 16'hFFFF,  18, 18, 8);
  endtask

  // Main sequence: reset once, run each test in turn, drain, and report.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_full_mode();
    test_off_and_reserved();
    test_trigger_capture();
    test_mode_change_in_capture();
    test_zero_post_count();
    test_random_capture();
    settle();
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("** iq_pretrigger_capture_top: PASSED **");
    end else begin
      $display("** iq_pretrigger_capture_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    #2000000;
    $display("** iq_pretrigger_capture_top: FAILED **");
    $finish;
  end

endmodule
